// ===== rtl/core/tdff_pkg.sv =====
// Shared constants for the trial division factor finder.
`default_nettype none
package tdff_pkg;
	localparam int WIDTH_DEFAULT = 32;
	localparam int NUMBER_W      = 32;
	localparam int FACTOR_W      = 16;
	localparam int COFACTOR_W    = 32;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 48;
	localparam int OUT_TUSER_W   = 1;
endpackage
`default_nettype wire

// ===== rtl/core/tdff_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module tdff_div #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic [WIDTH-1:0]      quotient,
	output logic [WIDTH-1:0]      remainder
);
	localparam int CW = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[WIDTH-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/tdff_sqrt.sv =====
// Digit-by-digit integer square root: two radicand bits, one root bit per cycle.
`default_nettype none
module tdff_sqrt #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [WIDTH-1:0] radicand,
	output logic                  done,
	output logic [(WIDTH+1)/2-1:0] root
);
	localparam int WE = WIDTH + (WIDTH % 2);
	localparam int R  = WE / 2;
	localparam int CW = $clog2(R + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [WE-1:0] rad_q;
	logic [R+1:0]  rem_q;
	logic [R-1:0]  root_q;

	logic [R+1:0]  rem_sh;
	logic [R+1:0]  trial;
	logic          ge;

	assign rem_sh = {rem_q[R-1:0], rad_q[WE-1:WE-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(R);
				rad_q  <= WE'(radicand);
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[R-2:0], ge};
				rad_q  <= {rad_q[WE-3:0], 2'b00};
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== rtl/core/trial_division_factor_finder_unit.sv =====
// Top level of the trial division factor finder.
//
// Channel  | Dir | Payload
// s_axis   | in  | tdata[31:0] number
// m_axis   | out | tdata[15:0] factor, tdata[47:16] cofactor; tuser[0] zero_error
//
// A square root is taken once per transaction and again per divisor found. Each trial
// division issues the divisor, runs the divider and then tests the remainder; a 32-bit
// prime near 2^32 needs about 65536 trials. A zero input skips the search and goes
// straight to the output register.
// No state survives between transactions. A finished result waits in the output
// register; the next number is taken meanwhile, and its result waits until that register is free.
`default_nettype none
module trial_division_factor_finder_unit #(
	parameter int WIDTH = tdff_pkg::WIDTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [tdff_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // number
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [tdff_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // factor, cofactor
	output logic [tdff_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // zero_error
);
	import tdff_pkg::*;

	localparam int R = (WIDTH + 1) / 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_N,
		ST_TEST_D,
		ST_DIV_N,
		ST_SQ_D,
		ST_TEST_E,
		ST_DIV_E,
		ST_QUO,
		ST_HOLD
	} state_t;

	state_t                state_q;
	logic [WIDTH-1:0]      n_q;
	logic [R-1:0]          d_q;
	logic [R-1:0]          e_q;

	logic                  sq_go_q;
	logic [WIDTH-1:0]      sq_arg_q;
	logic                  sq_done;
	logic [R-1:0]          sq_root;

	logic                  dv_go_q;
	logic [WIDTH-1:0]      dv_a_q;
	logic [WIDTH-1:0]      dv_b_q;
	logic                  dv_done;
	logic [WIDTH-1:0]      dv_quo;
	logic [WIDTH-1:0]      dv_rem;

	logic [FACTOR_W-1:0]   res_fac_q;
	logic [COFACTOR_W-1:0] res_cof_q;
	logic                  res_err_q;

	logic                  out_valid_q;
	logic [FACTOR_W-1:0]   out_fac_q;
	logic [COFACTOR_W-1:0] out_cof_q;
	logic                  out_err_q;

	logic [WIDTH-1:0]      n_in;

	assign n_in = WIDTH'(s_axis_tdata);

	tdff_sqrt #(.WIDTH(WIDTH)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go_q),
		.radicand (sq_arg_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	tdff_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (dv_go_q),
		.dividend  (dv_a_q),
		.divisor   (dv_b_q),
		.done      (dv_done),
		.quotient  (dv_quo),
		.remainder (dv_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sq_go_q     <= 1'b0;
			dv_go_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q != ST_HOLD && out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						n_q <= n_in;
						if (n_in == '0) begin
							res_fac_q <= '0;
							res_cof_q <= '0;
							res_err_q <= 1'b1;
							state_q   <= ST_HOLD;
						end else begin
							sq_arg_q <= n_in;
							sq_go_q  <= 1'b1;
							state_q  <= ST_SQ_N;
						end
					end
				end
				ST_SQ_N: begin
					sq_go_q <= 1'b0;
					if (sq_done) begin
						d_q     <= sq_root;
						state_q <= ST_TEST_D;
					end
				end
				ST_TEST_D: begin
					dv_a_q  <= n_q;
					dv_go_q <= 1'b1;
					if (d_q <= R'(1)) begin
						// no divisor above one: factor 1, cofactor n
						d_q     <= R'(1);
						dv_b_q  <= WIDTH'(1);
						state_q <= ST_QUO;
					end else begin
						dv_b_q  <= WIDTH'(d_q);
						state_q <= ST_DIV_N;
					end
				end
				ST_DIV_N: begin
					dv_go_q <= 1'b0;
					if (dv_done) begin
						if (dv_rem == '0) begin
							sq_arg_q <= WIDTH'(d_q);
							sq_go_q  <= 1'b1;
							state_q  <= ST_SQ_D;
						end else begin
							d_q     <= d_q - R'(1);
							state_q <= ST_TEST_D;
						end
					end
				end
				ST_SQ_D: begin
					sq_go_q <= 1'b0;
					if (sq_done) begin
						e_q     <= sq_root;
						state_q <= ST_TEST_E;
					end
				end
				ST_TEST_E: begin
					dv_go_q <= 1'b1;
					if (e_q <= R'(1)) begin
						// d has no smaller divisor: it is the factor
						dv_a_q  <= n_q;
						dv_b_q  <= WIDTH'(d_q);
						state_q <= ST_QUO;
					end else begin
						dv_a_q  <= WIDTH'(d_q);
						dv_b_q  <= WIDTH'(e_q);
						state_q <= ST_DIV_E;
					end
				end
				ST_DIV_E: begin
					dv_go_q <= 1'b0;
					if (dv_done) begin
						if (dv_rem == '0) begin
							// e divides d, hence n; descend into e
							d_q      <= e_q;
							sq_arg_q <= WIDTH'(e_q);
							sq_go_q  <= 1'b1;
							state_q  <= ST_SQ_D;
						end else begin
							e_q     <= e_q - R'(1);
							state_q <= ST_TEST_E;
						end
					end
				end
				ST_QUO: begin
					dv_go_q <= 1'b0;
					if (dv_done) begin
						res_fac_q <= FACTOR_W'(d_q);
						res_cof_q <= COFACTOR_W'(dv_quo);
						res_err_q <= 1'b0;
						state_q   <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_fac_q   <= res_fac_q;
						out_cof_q   <= res_cof_q;
						out_err_q   <= res_err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cof_q, out_fac_q};
	assign m_axis_tuser  = out_err_q;

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero_error result carries nonzero fields");

	a_factor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[FACTOR_W-1:0] != '0)
		else $error("factor of zero on a valid result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice without finishing");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_done && dv_done))
		else $error("square root and divider finished together");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the trial division factor finder unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tdff_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int TAIL_CYCLES = 200;

	typedef enum int {RX_FREE, RX_RANDOM, RX_HEAVY} rx_mode_t;

	typedef struct {
		logic [FACTOR_W-1:0]   factor;
		logic [COFACTOR_W-1:0] cofactor;
		logic                  zero_error;
		logic [NUMBER_W-1:0]   number;
	} factor_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // number
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // factor, cofactor
	logic [OUT_TUSER_W-1:0] m_axis_tuser;        // zero_error

	factor_result_t pending_factors[$];
	int             error_count = 0;
	int             items_sent = 0;
	int             results_seen = 0;
	int             zero_inputs = 0;
	int             cycle_count = 0;
	int             rx_hold = 0;
	rx_mode_t       rx_mode = RX_RANDOM;
	bit             tx_burst = 1'b0;

	trial_division_factor_finder_unit #(.WIDTH(WIDTH_DEFAULT)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		logic [63:0] bit_v;
		root = '0;
		bit_v = 64'h8000_0000;
		while (bit_v != 0) begin
			trial = root + bit_v;
			if (trial * trial <= v)
				root = trial;
			bit_v = bit_v >> 1;
		end
		return root;
	endfunction

	// largest e with 1 < e <= isqrt(d) that divides d, else 1
	function automatic logic [63:0] largest_inner_divisor(input logic [63:0] d);
		logic [63:0] e;
		e = int_sqrt(d);
		while (e > 1) begin
			if (d % e == 0)
				return e;
			e--;
		end
		return 64'd1;
	endfunction

	function automatic factor_result_t compute_factor(input logic [NUMBER_W-1:0] num);
		factor_result_t r;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] e;
		logic [63:0] q;
		n = 64'(num);
		r.number = num;
		if (n == 0) begin
			r.factor = '0;
			r.cofactor = '0;
			r.zero_error = 1'b1;
			return r;
		end
		d = int_sqrt(n);
		forever begin
			if (d <= 1) begin
				d = 1;
				break;
			end
			if (n % d == 0) begin
				e = largest_inner_divisor(d);
				if (e == 1)
					break;
				d = e;
			end else begin
				d--;
			end
		end
		q = n / d;
		r.factor = d[FACTOR_W-1:0];
		r.cofactor = q[COFACTOR_W-1:0];
		r.zero_error = 1'b0;
		return r;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string msg);
		$display("[%0d] MISMATCH: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_result;
		factor_result_t want;
		logic [FACTOR_W-1:0]   got_factor;
		logic [COFACTOR_W-1:0] got_cofactor;
		logic                  got_zero;
		got_factor = m_axis_tdata[FACTOR_W-1:0];
		got_cofactor = m_axis_tdata[FACTOR_W +: COFACTOR_W];
		got_zero = m_axis_tuser[0];
		results_seen++;
		if (pending_factors.size() == 0) begin
			report_mismatch($sformatf("unexpected result factor=%0d cofactor=%0d zero=%0b",
				got_factor, got_cofactor, got_zero));
			return;
		end
		want = pending_factors.pop_front();
		if (got_factor !== want.factor)
			report_mismatch($sformatf("n=%0d factor got %0d want %0d",
				want.number, got_factor, want.factor));
		if (got_cofactor !== want.cofactor)
			report_mismatch($sformatf("n=%0d cofactor got %0d want %0d",
				want.number, got_cofactor, want.cofactor));
		if (got_zero !== want.zero_error)
			report_mismatch($sformatf("n=%0d zero_error got %0b want %0b",
				want.number, got_zero, want.zero_error));
	endtask

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		int r;
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			case (rx_mode)
				RX_FREE: begin
					m_axis_tready <= 1'b1;
				end
				RX_RANDOM: begin
					if (r < 65) begin
						m_axis_tready <= 1'b1;
					end else begin
						m_axis_tready <= 1'b0;
						rx_hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 60);
					end
				end
				default: begin
					if (r < 20) begin
						m_axis_tready <= 1'b1;
					end else begin
						m_axis_tready <= 1'b0;
						rx_hold = $urandom_range(40, 200);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_factors.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_number(input logic [NUMBER_W-1:0] num);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= num;
		do @(posedge clk); while (!s_axis_tready);
		pending_factors.push_back(compute_factor(num));
		items_sent++;
		if (num == 0)
			zero_inputs++;
	endtask

	// sender holds off until every outstanding result has come back
	task automatic wait_for_results;
		s_axis_tvalid <= 1'b0;
		while (pending_factors.size() != 0) @(posedge clk);
	endtask

	// random value of 1..16 bits, so trial counts stay short
	function automatic logic [NUMBER_W-1:0] small_number();
		int w;
		w = $urandom_range(1, 16);
		return NUMBER_W'($urandom & ((32'd1 << w) - 1));
	endfunction

	// products whose largest divisor below the root sits right at the root
	function automatic logic [NUMBER_W-1:0] near_square_product();
		logic [63:0] a;
		logic [63:0] p;
		if ($urandom_range(0, 1) == 1)
			a = 64'($urandom_range(32768, 65535));
		else
			a = 64'($urandom_range(2, 65535));
		case ($urandom_range(0, 3))
			0: p = a * a;
			1: p = a * (a + 1);
			2: p = a * (a + 2);
			default: p = a * a - 1;
		endcase
		return p[NUMBER_W-1:0];
	endfunction

	task automatic test_directed;
		logic [NUMBER_W-1:0] vals[$];
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd0, 32'd0, 32'd6, 32'd9,
			32'd12, 32'd15, 32'd16, 32'd25, 32'd97, 32'd65521, 32'd65536,
			32'h4000_0000, 32'hFFFE_0001, 32'hFFFF_FFFF, 32'd0, 32'd1};
		rx_mode = RX_RANDOM;
		foreach (vals[i])
			send_number(vals[i]);
		wait_for_results();
	endtask

	task automatic test_small_numbers;
		rx_mode = RX_RANDOM;
		repeat (35) begin
			if ($urandom_range(0, 19) == 0)
				send_number('0);
			else
				send_number(small_number());
		end
		wait_for_results();
	endtask

	task automatic test_wide_products;
		int r;
		rx_mode = RX_RANDOM;
		repeat (40) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				send_number(near_square_product());
			else if (r < 95)
				send_number(small_number());
			else
				send_number('0);
		end
		wait_for_results();
	endtask

	task automatic test_flow_control;
		// receiver stalls hard while the sender streams with no gaps
		rx_mode = RX_HEAVY;
		tx_burst = 1'b1;
		repeat (12) begin
			if ($urandom_range(0, 3) == 0)
				send_number(near_square_product());
			else
				send_number(small_number());
		end
		wait_for_results();
		// no idling on either side
		rx_mode = RX_FREE;
		repeat (12) begin
			if ($urandom_range(0, 4) == 0)
				send_number('0);
			else
				send_number(small_number());
		end
		tx_burst = 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_numbers();
		test_wide_products();
		test_flow_control();
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_factors.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_factors.size()));
		$display("summary: %0d numbers sent (%0d zero), %0d results checked, %0d errors",
			items_sent, zero_inputs, results_seen, error_count);
		$display("summary: small values, near-square wide products, stalls and bursts");
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

// ===== trial_division_factor_finder_unit.f =====
rtl/core/tdff_pkg.sv
rtl/core/tdff_div.sv
rtl/core/tdff_sqrt.sv
rtl/core/trial_division_factor_finder_unit.sv
tb/tb_top.sv
